### rtl/mmn_pkg.sv
package mmn_pkg;

  localparam int unsigned SmpW = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_LOAD   = 2'd1,
    ACT_READ   = 2'd2,
    ACT_RSVD   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_NORM = 2'd0,
    ST_PASS = 2'd1,
    ST_ZERO = 2'd2,
    ST_BAD  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    DOM_ROW    = 2'd0,
    DOM_COLUMN = 2'd1,
    DOM_GLOBAL = 2'd2,
    DOM_RSVD   = 2'd3
  } domain_e;

  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_DOMAIN = 3'd1,
    REG_LOWER  = 3'd2,
    REG_UPPER  = 3'd3,
    REG_ROWS   = 3'd4,
    REG_COLS   = 3'd5,
    REG_TAIL   = 3'd6,
    REG_NONE   = 3'd7
  } reg_e;

  typedef struct packed {
    logic [1:0]        action;
    logic [5:0]        row;
    logic [5:0]        column;
    logic signed [SmpW-1:0] sample;
    logic [5:0]        channel;
    logic signed [SmpW-1:0] load_min;
    logic signed [SmpW-1:0] load_max;
  } in_item_t;

  typedef struct packed {
    logic signed [SmpW-1:0] result;
    logic [1:0]        status;
    logic signed [SmpW-1:0] min_out;
    logic signed [SmpW-1:0] max_out;
  } out_item_t;

endpackage

### rtl/min_max_normalizer_unit.sv
// Channel | Signals                          | Direction
// in      | in_valid_i, in_stall_o, in_i     | input beats
// out     | out_valid_o, out_stall_i, out_o  | result beats
// cfg     | cfg_valid_i, cfg_ready_o, cfg_*  | register writes
// A train sample, a load or a read passes through the READ, EXEC and OUT states before
// its result is valid; a normalized sample adds a serial multiply (MUL), a serial divide
// (DIV) and the final add (FIN) before OUT.
// The input stalls until the result beat is taken and accepts again in the cycle after.
// After reset a clearing pass over all CHANNELS table entries runs before the first beat;
// the first train sample after reset or after predict reruns it, then rereads its entry.
module min_max_normalizer_unit import mmn_pkg::*; #(
  parameter int unsigned CHANNELS    = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned AW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned MW  = SmpW + 1;
  localparam int unsigned PW  = 2 * MW;
  localparam logic signed [SmpW-1:0] SMax = {1'b0, {(SmpW-1){1'b1}}};
  localparam logic signed [SmpW-1:0] SMin = {1'b1, {(SmpW-1){1'b0}}};

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_READ  = 8'b0000_0100,
    S_EXEC  = 8'b0000_1000,
    S_MUL   = 8'b0001_0000,
    S_DIV   = 8'b0010_0000,
    S_FIN   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic                   mode_q;
  logic [1:0]             domain_q;
  logic signed [SmpW-1:0] lower_q, upper_q;
  logic [6:0]             rows_q, cols_q, tail_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      domain_q <= DOM_ROW;
      lower_q <= '0;
      upper_q <= SMax;
      rows_q <= 7'd1;
      cols_q <= 7'd1;
      tail_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_MODE:   mode_q <= cfg_data_i[0];
        REG_DOMAIN: domain_q <= cfg_data_i[1:0];
        REG_LOWER:  lower_q <= cfg_data_i[SmpW-1:0];
        REG_UPPER:  upper_q <= cfg_data_i[SmpW-1:0];
        REG_ROWS:   rows_q <= cfg_data_i[6:0];
        REG_COLS:   cols_q <= cfg_data_i[6:0];
        REG_TAIL:   tail_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Item register and table memories
  in_item_t               item_q;
  logic [AW-1:0]          idx_q, idx_d;
  logic [AW-1:0]          clr_q, clr_d;
  logic                   prev_q, prev_d;
  logic signed [SmpW-1:0] mn_q, mx_q;
  logic signed [SmpW-1:0] min_mem [CHANNELS];
  logic signed [SmpW-1:0] max_mem [CHANNELS];
  logic                   we;
  logic [AW-1:0]          waddr;
  logic signed [SmpW-1:0] wmin, wmax;
  logic                   resume_q, resume_d;

  always_ff @(posedge clk_i) begin
    if (we) begin
      min_mem[waddr] <= wmin;
      max_mem[waddr] <= wmax;
    end
    mn_q <= min_mem[idx_q];
    mx_q <= max_mem[idx_q];
  end

  // Item decode
  logic       is_sample, in_frame, bad_rng, in_body, glob_start;
  logic [5:0] pos;
  logic [6:0] cnt;
  logic [AW-1:0] idx_new;
  logic [7:0] limit;

  assign pos = (domain_q == DOM_COLUMN) ? in_i.column : in_i.row;
  assign idx_new = (in_i.action != ACT_SAMPLE) ? AW'(in_i.channel % CHANNELS) :
                   (domain_q == DOM_GLOBAL) ? '0 : AW'(pos % CHANNELS);
  assign cnt = (domain_q == DOM_COLUMN) ? cols_q : rows_q;
  assign limit = {1'b0, cnt} - {1'b0, tail_q};
  assign is_sample = (item_q.action == ACT_SAMPLE);
  assign bad_rng = lower_q > upper_q;
  assign in_frame = ({1'b0, item_q.row} < rows_q) && ({1'b0, item_q.column} < cols_q);
  assign glob_start = (domain_q == DOM_GLOBAL) && (item_q.row == '0) && (item_q.column == '0);

  logic [5:0] pos_q;
  logic [7:0] limit_q;
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE) begin
      pos_q <= pos;
      limit_q <= limit;
    end
  end
  assign in_body = $signed({2'b0, pos_q}) < $signed(limit_q);

  // Serial arithmetic operands
  logic signed [MW-1:0] d_s, s_s, r_s;
  logic [MW-1:0]        ud, us, ur;
  logic                 neg_q, neg_d;
  logic                 mul_start, mul_done, div_start, div_done;
  logic [PW-1:0]        prod, quot;
  logic [MW-1:0]        den_q, den_d;

  assign d_s = MW'(item_q.sample) - MW'(mn_q);
  assign s_s = MW'(mx_q) - MW'(mn_q);
  assign r_s = MW'(upper_q) - MW'(lower_q);
  assign ud = d_s[MW-1] ? MW'(-d_s) : d_s;
  assign us = s_s[MW-1] ? MW'(-s_s) : s_s;
  assign ur = r_s;

  mmn_multiplier #(.AW(MW), .BW(MW)) u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(ud), .b_i(ur),
    .done_o(mul_done), .prod_o(prod)
  );

  mmn_divider #(.NumW(PW), .DenW(MW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(prod), .den_i(den_q),
    .done_o(div_done), .quot_o(quot)
  );

  // Final add and saturate
  logic [PW-1:0]          qc;
  logic signed [PW+1:0]   sum;
  logic signed [SmpW-1:0] norm;
  assign qc = quot;
  assign sum = neg_q ? ((PW+2)'(lower_q) - $signed({2'b0, qc}))
                     : ((PW+2)'(lower_q) + $signed({2'b0, qc}));
  assign norm = (sum > (PW+2)'(SMax)) ? SMax :
                (sum < (PW+2)'(SMin)) ? SMin : SmpW'(sum);

  out_item_t out_q, out_d;
  logic      ov_q, ov_d;

  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    clr_d = clr_q;
    prev_d = prev_q;
    resume_d = resume_q;
    neg_d = neg_q;
    den_d = den_q;
    out_d = out_q;
    ov_d = ov_q;
    we = 1'b0;
    waddr = idx_q;
    wmin = mn_q;
    wmax = mx_q;
    mul_start = 1'b0;
    div_start = 1'b0;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    unique case (state_q)
      // Sweep both tables to reset values
      S_CLEAR: begin
        we = 1'b1;
        waddr = clr_q;
        wmin = SMax;
        wmax = SMin;
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(CHANNELS - 1)) begin
          clr_d = '0;
          state_d = resume_q ? S_READ : S_IDLE;
          resume_d = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_valid_i && !ov_q) begin
          idx_d = idx_new;
          state_d = S_READ;
        end
      end
      S_READ: state_d = S_EXEC;
      S_EXEC: begin
        out_d.result = '0;
        out_d.status = ST_NORM;
        out_d.min_out = mn_q;
        out_d.max_out = mx_q;
        state_d = S_OUT;
        if (!is_sample) begin
          if (item_q.action == ACT_LOAD) begin
            we = 1'b1;
            wmin = item_q.load_min;
            wmax = item_q.load_max;
            out_d.min_out = item_q.load_min;
            out_d.max_out = item_q.load_max;
          end
        end else begin
          out_d.result = item_q.sample;
          out_d.status = ST_PASS;
          if (bad_rng) begin
            out_d.status = ST_BAD;
          end else if (in_frame) begin
            prev_d = mode_q;
            if (!mode_q) begin
              if (prev_q) begin
                resume_d = 1'b1;
                state_d = S_CLEAR;
              end else begin
                we = 1'b1;
                wmin = glob_start ? SMax : mn_q;
                wmax = glob_start ? SMin : mx_q;
                if (item_q.sample > wmax) wmax = item_q.sample;
                if (item_q.sample < wmin) wmin = item_q.sample;
                out_d.min_out = wmin;
                out_d.max_out = wmax;
              end
            end else if (in_body) begin
              if (mx_q == mn_q) begin
                out_d.result = lower_q;
                out_d.status = ST_ZERO;
              end else begin
                neg_d = d_s[MW-1] ^ s_s[MW-1];
                den_d = us;
                mul_start = 1'b1;
                state_d = S_MUL;
              end
            end
          end
        end
      end
      S_MUL: if (mul_done) begin
        div_start = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: if (div_done) state_d = S_FIN;
      S_FIN: begin
        out_d.result = norm;
        out_d.status = ST_NORM;
        state_d = S_OUT;
      end
      S_OUT: begin
        ov_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      prev_q <= 1'b1;
      resume_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      prev_q <= prev_d;
      resume_q <= resume_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    neg_q <= neg_d;
    den_q <= den_d;
    out_q <= out_d;
    if (state_q == S_IDLE && in_valid_i && !ov_q) item_q <= in_i;
  end

  assign in_stall_o = (state_q != S_IDLE) || ov_q;
  assign out_valid_o = ov_q;
  assign out_o = out_q;

endmodule

### rtl/mmn_divider.sv
module mmn_divider import mmn_pkg::*; #(
  parameter int unsigned NumW = 34,
  parameter int unsigned DenW = 18
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quot_q, quot_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DenW:0]   trial;

  // One quotient bit per cycle, restoring radix 2
  assign trial = {rem_q[DenW-1:0], quot_q[NumW-1]};

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d  = trial - {1'b0, den_q};
        quot_d = {quot_q[NumW-2:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### rtl/mmn_multiplier.sv
module mmn_multiplier import mmn_pkg::*; #(
  parameter int unsigned AW = 17,
  parameter int unsigned BW = 17
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic             done_o,
  output logic [AW+BW-1:0] prod_o
);

  localparam int unsigned CntW = $clog2(BW + 1);

  logic [AW+BW-1:0] acc_q, acc_d;
  logic [AW-1:0]    a_q, a_d;
  logic [BW-1:0]    b_q, b_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;

  // Shift-add, one multiplier bit per cycle from the top
  always_comb begin
    acc_d = acc_q;
    a_d = a_q;
    b_d = b_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d = '0;
      a_d = a_i;
      b_d = b_i;
      cnt_d = CntW'(BW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = {acc_q[AW+BW-2:0], 1'b0} + (b_q[BW-1] ? {{BW{1'b0}}, a_q} : '0);
      b_d = {b_q[BW-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q <= a_d;
    b_q <= b_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule
